/* sv/mcsl_pkg.sv */
// ----------------------------------------------------------------------------
// mcsl_pkg
// Shared types, constants and mod-Q helpers for the masked S-box layer.
// ----------------------------------------------------------------------------
package mcsl_pkg;

    localparam int unsigned MODULUS    = 65537;
    localparam int unsigned FIELD_W    = 17;
    localparam int unsigned PROD_W     = 2 * FIELD_W - 1;
    localparam logic [FIELD_W:0] MOD_Q = (FIELD_W + 1)'(MODULUS);

    typedef logic [FIELD_W-1:0] t_elem;

    typedef struct packed {
        t_elem in_share0;
        t_elem in_share1;
        t_elem refresh_first;
        t_elem refresh_second;
        logic  first_coeff;
    } t_in_word;

    typedef struct packed {
        t_elem out_share0;
        t_elem out_share1;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_END,
        S_CU_MUL,
        S_CU_END,
        S_DONE
    } t_state;

    // Product select: a0*b0, a0*b1, a1*b0, a1*b1
    typedef enum logic [1:0] {
        P_A0B0,
        P_A0B1,
        P_A1B0,
        P_A1B1
    } t_prod_sel;

    typedef struct packed {
        logic      load;      // latch a new input word
        logic      mul_en;    // issue one product
        t_prod_sel mul_sel;
        logic      mul_cube;  // B operand is the new square
        logic      acc_en;    // fold the registered product in
        logic      acc_c0;    // product belongs to share 0
        logic      sq_end;    // square done: hold it, reseed the accumulator
        logic      done;      // write the result word, commit the square
        logic      out_cube;  // result from the accumulator
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Reduce a value below 2*Q.
    function automatic t_elem mod_fold(input logic [FIELD_W:0] x);
        logic [FIELD_W:0] d;
        d = x - MOD_Q;
        mod_fold = (x >= MOD_Q) ? d[FIELD_W-1:0] : x[FIELD_W-1:0];
    endfunction

    function automatic t_elem mod_add(input t_elem a, input t_elem b);
        mod_add = mod_fold({1'b0, a} + {1'b0, b});
    endfunction

    function automatic t_elem mod_neg(input t_elem r);
        logic [FIELD_W:0] d;
        d = MOD_Q - {1'b0, r};
        mod_neg = (r == '0) ? '0 : d[FIELD_W-1:0];
    endfunction

    // Q = 2^16 + 1: x = hi*2^16 + lo is congruent to lo - hi.
    function automatic t_elem mod_prod(input logic [PROD_W-1:0] p);
        logic [FIELD_W:0] hi;
        logic [FIELD_W:0] lo;
        logic [FIELD_W:0] d;
        hi = {1'b0, p[PROD_W-1:FIELD_W-1]};
        lo = {2'b00, p[FIELD_W-2:0]};
        d  = (lo >= hi) ? (lo - hi) : (lo + MOD_Q - hi);
        mod_prod = d[FIELD_W-1:0];
    endfunction

endpackage

/* sv/masked_cipher_sbox_layer.sv */
// ----------------------------------------------------------------------------
// masked_cipher_sbox_layer
// Two-share masked S-box layer mod 65537 (Feistel square-add or cube).
// ----------------------------------------------------------------------------
// Schedule: one 17x17 multiplier issues 4 products in Feistel mode and 8 in
//   cube mode; a new word is accepted only in idle, once the previous result
//   word has been written to the output register, which lets the next word
//   enter while the result waits for the receiver.
// Reset: synchronous active-low clears the sequencer, the mode (Feistel), the
//   stored previous square and the output valid.
// ----------------------------------------------------------------------------
module masked_cipher_sbox_layer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mcsl_pkg::t_in_word  i_in_word,
    // result words
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mcsl_pkg::t_out_word o_out_word,
    // mode register: 0 Feistel square-add, 1 cube
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import mcsl_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer: load, four square products, optional four cube products,
    // then write the result word and commit the new square.
    mcsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: registered multiply, then fold-and-accumulate mod Q in the
    // next cycle; the square is kept for the next coefficient.
    mcsl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

/* sv/mcsl_ctrl.sv */
// ----------------------------------------------------------------------------
// mcsl_ctrl
// Sequencer for the shared multiplier: square, optional cube, result write.
// ----------------------------------------------------------------------------
module mcsl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data,
    input  mcsl_pkg::t_dp_status i_status,
    output mcsl_pkg::t_dp_cmd   o_cmd
);
    import mcsl_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = t_prod_sel'(r_cnt);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SQ_MUL;
                end
            end
            S_SQ_MUL, S_CU_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_cube = (r_state == S_CU_MUL);
                // product issued last cycle lands now
                o_cmd.acc_en   = (r_cnt != 2'd0);
                o_cmd.acc_c0   = (r_cnt == 2'd1);
                n_cnt          = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = (r_state == S_CU_MUL) ? S_CU_END : S_SQ_END;
                end
            end
            S_SQ_END: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.sq_end = 1'b1;
                n_cnt        = '0;
                n_state      = r_mode ? S_CU_MUL : S_DONE;
            end
            S_CU_END: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the word
                if (i_status.out_free) begin
                    o_cmd.done     = 1'b1;
                    o_cmd.out_cube = r_mode;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/mcsl_dp.sv */
// ----------------------------------------------------------------------------
// mcsl_dp
// Operand registers, shared 17x17 multiplier, mod-Q accumulators, output word.
// ----------------------------------------------------------------------------
module mcsl_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mcsl_pkg::t_in_word   i_in_word,
    input  mcsl_pkg::t_dp_cmd    i_cmd,
    output mcsl_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mcsl_pkg::t_out_word  o_out_word
);
    import mcsl_pkg::*;

    t_elem             r_a0, r_a1, r_r2;
    logic              r_first;
    t_elem             r_acc0, r_acc1, n_acc0, n_acc1;
    t_elem             r_sq0, r_sq1;
    t_elem             r_prev0, r_prev1;
    logic [PROD_W-1:0] r_prod;
    t_out_word         r_out;
    logic              r_out_valid;

    t_elem             op_a, op_b, b0, b1, red, in_r1;
    logic [PROD_W-1:0] full_prod;

    assign in_r1 = mod_fold({1'b0, i_in_word.refresh_first});

    assign b0 = i_cmd.mul_cube ? r_sq0 : r_a0;
    assign b1 = i_cmd.mul_cube ? r_sq1 : r_a1;

    always_comb begin
        case (i_cmd.mul_sel)
            P_A0B0:  begin op_a = r_a0; op_b = b0; end
            P_A0B1:  begin op_a = r_a0; op_b = b1; end
            P_A1B0:  begin op_a = r_a1; op_b = b0; end
            P_A1B1:  begin op_a = r_a1; op_b = b1; end
            default: begin op_a = r_a0; op_b = b0; end
        endcase
    end

    // both operands are below Q, so the product fits in PROD_W bits
    assign full_prod = PROD_W'(op_a) * PROD_W'(op_b);
    assign red       = mod_prod(r_prod);

    always_comb begin
        n_acc0 = r_acc0;
        n_acc1 = r_acc1;
        if (i_cmd.acc_en) begin
            if (i_cmd.acc_c0) begin
                n_acc0 = mod_add(r_acc0, red);
            end else begin
                n_acc1 = mod_add(r_acc1, red);
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a0    <= mod_fold({1'b0, i_in_word.in_share0});
            r_a1    <= mod_fold({1'b0, i_in_word.in_share1});
            r_r2    <= mod_fold({1'b0, i_in_word.refresh_second});
            r_first <= i_in_word.first_coeff;
            r_acc0  <= mod_neg(in_r1);
            r_acc1  <= in_r1;
        end else if (i_cmd.sq_end) begin
            r_sq0  <= n_acc0;
            r_sq1  <= n_acc1;
            r_acc0 <= mod_neg(r_r2);
            r_acc1 <= r_r2;
        end else begin
            r_acc0 <= n_acc0;
            r_acc1 <= n_acc1;
        end
        if (i_cmd.mul_en) begin
            r_prod <= full_prod;
        end
        if (i_cmd.done) begin
            if (i_cmd.out_cube) begin
                r_out.out_share0 <= r_acc0;
                r_out.out_share1 <= r_acc1;
            end else if (r_first) begin
                r_out.out_share0 <= r_a0;
                r_out.out_share1 <= r_a1;
            end else begin
                r_out.out_share0 <= mod_add(r_a0, r_prev0);
                r_out.out_share1 <= mod_add(r_a1, r_prev1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev0     <= '0;
            r_prev1     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.done) begin
                r_prev0     <= r_sq0;
                r_prev1     <= r_sq1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
